// ===== src/anbs_pkg.sv =====
// Shared types and constants for the Annex B NAL unit splitter.
// Used by every module under src; depends on nothing.
package anbs_pkg;

  localparam int unsigned LookDepth = 4;
  localparam int unsigned BurstMax  = 5;

  // Timestamp split: ts / 1e6 = (ts >> 6) / 15625, long division in three digits.
  localparam logic [13:0] DivD     = 14'd15625;
  localparam logic [30:0] DivRecip = 31'd1125899907;
  localparam int unsigned DivShift = 44;

  typedef struct packed {
    logic [7:0] data;
    logic       frame_end;
  } in_item_t;

  typedef struct packed {
    logic [44:0] sec;
    logic [19:0] usec;
  } pts_t;

  typedef struct packed {
    logic [7:0] data;
    logic       first;
    logic       last;
  } res_t;

  typedef struct packed {
    res_t [BurstMax-1:0] res;
    logic [2:0]          cnt;
  } burst_t;

endpackage

// ===== src/annexb_nal_unit_splitter.sv =====
// Annex B NAL unit splitter: strips start codes, emits unit payload bytes.
// Throughput: one input byte per cycle while the output accepts results; a byte that
// yields k > 1 results holds the input while the result register drains.
// Reset: asynchronous, active low; parser returns to "before first start code".
module annexb_nal_unit_splitter import anbs_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid_i,
  output logic        s_axis_tready_o,
  input  logic [71:0] s_axis_tdata_i,  // data_byte[7:0], timestamp_us[71:8]
  input  logic        s_axis_tlast_i,
  output logic        m_axis_tvalid_o,
  input  logic        m_axis_tready_i,
  output logic [79:0] m_axis_tdata_o,  // payload_byte[7:0], pts_seconds[52:8], pts_micros[72:53]
  output logic [1:0]  m_axis_tuser_o,  // unit_first[0], burst_last[1]
  output logic        m_axis_tlast_o
);

  in_item_t in_item, div_item;
  pts_t     div_pts, out_pts;
  burst_t   burst;
  res_t     out_res;
  logic     div_valid, load_ok, load, en, burst_last;

  assign in_item.data      = s_axis_tdata_i[7:0];
  assign in_item.frame_end = s_axis_tlast_i;

  assign en              = !div_valid || load_ok;
  assign load            = div_valid && load_ok;
  assign s_axis_tready_o = en;

  anbs_ts_div u_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (en),
    .valid_i (s_axis_tvalid_i),
    .item_i  (in_item),
    .ts_i    (s_axis_tdata_i[71:8]),
    .valid_o (div_valid),
    .item_o  (div_item),
    .pts_o   (div_pts)
  );

  anbs_parse u_parse (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .load_i  (load),
    .item_i  (div_item),
    .burst_o (burst)
  );

  anbs_burst u_burst (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .load_i       (load),
    .burst_i      (burst),
    .pts_i        (div_pts),
    .ready_i      (m_axis_tready_i),
    .load_ok_o    (load_ok),
    .valid_o      (m_axis_tvalid_o),
    .res_o        (out_res),
    .pts_o        (out_pts),
    .burst_last_o (burst_last)
  );

  assign m_axis_tdata_o = {7'b0, out_pts.usec, out_pts.sec, out_res.data};
  assign m_axis_tuser_o = {burst_last, out_res.first};
  assign m_axis_tlast_o = out_res.last;

`ifndef SYNTHESIS
  a_usec_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o |-> out_pts.usec < 20'd1000000)
    else $error("pts_micros out of range");

  a_stall_cause: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !s_axis_tready_o |-> div_valid && m_axis_tvalid_o)
    else $error("input stalled without a pending burst");

  a_burst_cont: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && m_axis_tready_i && !m_axis_tuser_o[1] |=> m_axis_tvalid_o)
    else $error("burst ended before its last result");
`endif

endmodule

// ===== src/anbs_ts_div.sv =====
// Input register and timestamp split pipeline (seconds and microseconds).
// Carries the byte item alongside; depends on anbs_pkg.
module anbs_ts_div import anbs_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        en_i,
  input  logic        valid_i,
  input  in_item_t    item_i,
  input  logic [63:0] ts_i,
  output logic        valid_o,
  output in_item_t    item_o,
  output pts_t        pts_o
);

  logic [6:0]  v_q;
  in_item_t    item_q [7];
  logic [63:0] ts0_q;

  logic [29:0] n0_q, n1_q, n2_q;
  logic [16:0] q0_1_q, q0_2_q, q0_3_q, q0_4_q, q0_5_q, q0_6_q;
  logic [15:0] q1_3_q, q1_4_q, q1_5_q, q1_6_q;
  logic [11:0] q2_5_q, q2_6_q;
  logic [13:0] r0_q, r1_q, r2_q;
  logic [33:0] rest1_q, rest2_q;
  logic [17:0] rest3_q, rest4_q;
  logic [5:0]  low5_q, low6_q;

  logic [60:0] p0, p1, p2;
  logic [29:0] n1_d, n2_d;
  logic [29:0] m0, m1, m2;

  always_comb begin
    n1_d = {r0_q, rest2_q[33:18]};
    n2_d = {4'b0, r1_q, rest4_q[17:6]};
    p0   = {31'b0, ts0_q[63:34]} * {30'b0, DivRecip};
    p1   = {31'b0, n1_d} * {30'b0, DivRecip};
    p2   = {31'b0, n2_d} * {30'b0, DivRecip};
    m0   = {13'b0, q0_1_q} * {16'b0, DivD};
    m1   = {14'b0, q1_3_q} * {16'b0, DivD};
    m2   = {18'b0, q2_5_q} * {16'b0, DivD};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= '0;
    end else if (en_i) begin
      v_q <= {v_q[5:0], valid_i};
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      item_q[0] <= item_i;
      for (int i = 1; i < 7; i++) begin
        item_q[i] <= item_q[i-1];
      end
      ts0_q   <= ts_i;
      // digit 0
      n0_q    <= ts0_q[63:34];
      q0_1_q  <= p0[DivShift+16:DivShift];
      rest1_q <= ts0_q[33:0];
      r0_q    <= 14'(n0_q - m0);
      q0_2_q  <= q0_1_q;
      rest2_q <= rest1_q;
      // digit 1
      n1_q    <= n1_d;
      q1_3_q  <= p1[DivShift+15:DivShift];
      q0_3_q  <= q0_2_q;
      rest3_q <= rest2_q[17:0];
      r1_q    <= 14'(n1_q - m1);
      q0_4_q  <= q0_3_q;
      q1_4_q  <= q1_3_q;
      rest4_q <= rest3_q;
      // digit 2
      n2_q    <= n2_d;
      q2_5_q  <= p2[DivShift+11:DivShift];
      q0_5_q  <= q0_4_q;
      q1_5_q  <= q1_4_q;
      low5_q  <= rest4_q[5:0];
      r2_q    <= 14'(n2_q - m2);
      q0_6_q  <= q0_5_q;
      q1_6_q  <= q1_5_q;
      q2_6_q  <= q2_5_q;
      low6_q  <= low5_q;
    end
  end

  assign valid_o    = v_q[6];
  assign item_o     = item_q[6];
  assign pts_o.sec  = {q0_6_q, q1_6_q, q2_6_q};
  assign pts_o.usec = {r2_q, low6_q};

endmodule

// ===== src/anbs_parse.sv =====
// Start code parser: lookahead bytes, unit state and the result list of one byte.
// Depends on anbs_pkg.
module anbs_parse import anbs_pkg::*; (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     load_i,
  input  in_item_t item_i,
  output burst_t   burst_o
);

  logic [7:0] look_q [LookDepth];
  logic [2:0] cnt_q;
  logic       inside_q;
  logic       first_q;

  logic [7:0] look_d [LookDepth];
  logic [2:0] cnt_d;
  logic       inside_d;
  logic       first_d;

  logic [2:0] tz, zc, k1raw, k1, k2, m;
  logic       run, is_zero, is_sc, inside_mid, first_mid;

  always_comb begin
    tz  = '0;
    run = 1'b1;
    for (int i = LookDepth - 1; i >= 0; i--) begin
      if (3'(i) < cnt_q) begin
        if (run && look_q[i] == 8'd0) begin
          tz = tz + 3'd1;
        end else begin
          run = 1'b0;
        end
      end
    end

    is_zero = item_i.data == 8'd0;
    is_sc   = item_i.data == 8'd1 && tz >= 3'd2;
    zc      = (tz >= 3'd3) ? 3'd3 : tz;
    look_d  = look_q;

    if (is_zero) begin
      if (cnt_q == 3'(LookDepth)) begin
        k1raw = 3'd1;
        for (int i = 0; i < LookDepth - 1; i++) begin
          look_d[i] = look_q[i+1];
        end
        look_d[LookDepth-1] = 8'd0;
        cnt_d = cnt_q;
      end else begin
        k1raw = '0;
        look_d[cnt_q[1:0]] = 8'd0;
        cnt_d = cnt_q + 3'd1;
      end
    end else if (is_sc) begin
      k1raw = cnt_q - zc;
      cnt_d = '0;
    end else begin
      k1raw     = cnt_q;
      look_d[0] = item_i.data;
      cnt_d     = 3'd1;
    end

    k1         = inside_q ? k1raw : 3'd0;
    inside_mid = is_sc | inside_q;
    first_mid  = is_sc ? 1'b1 : ((k1 != 3'd0) ? 1'b0 : first_q);
    k2         = (item_i.frame_end && inside_mid) ? cnt_d : 3'd0;

    for (int j = 0; j < BurstMax; j++) begin
      m = 3'(j) - k1;
      if (3'(j) < k1) begin
        burst_o.res[j].data  = look_q[2'(j)];
        burst_o.res[j].first = (j == 0) && first_q;
        burst_o.res[j].last  = is_sc && (3'(j) == k1 - 3'd1);
      end else begin
        burst_o.res[j].data  = look_d[m[1:0]];
        burst_o.res[j].first = (3'(j) == k1) && first_mid;
        burst_o.res[j].last  = (m == k2 - 3'd1);
      end
    end
    burst_o.cnt = k1 + k2;

    inside_d = item_i.frame_end ? 1'b0 : inside_mid;
    first_d  = item_i.frame_end ? 1'b1 : first_mid;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q    <= '0;
      inside_q <= 1'b0;
      first_q  <= 1'b1;
    end else if (load_i) begin
      cnt_q    <= item_i.frame_end ? 3'd0 : cnt_d;
      inside_q <= inside_d;
      first_q  <= first_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_i) begin
      look_q <= look_d;
    end
  end

endmodule

// ===== src/anbs_burst.sv =====
// Result register: holds the results of one byte and drains one per transfer.
// Depends on anbs_pkg.
module anbs_burst import anbs_pkg::*; (
  input  logic   clk_i,
  input  logic   rst_ni,
  input  logic   load_i,
  input  burst_t burst_i,
  input  pts_t   pts_i,
  input  logic   ready_i,
  output logic   load_ok_o,
  output logic   valid_o,
  output res_t   res_o,
  output pts_t   pts_o,
  output logic   burst_last_o
);

  res_t [BurstMax-1:0] res_q;
  logic [2:0]          cnt_q;
  pts_t                pts_q;
  logic                pop;

  assign valid_o      = cnt_q != 3'd0;
  assign pop          = valid_o && ready_i;
  assign load_ok_o    = (cnt_q == 3'd0) || (cnt_q == 3'd1 && ready_i);
  assign res_o        = res_q[0];
  assign pts_o        = pts_q;
  assign burst_last_o = cnt_q == 3'd1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= '0;
    end else if (load_i) begin
      cnt_q <= burst_i.cnt;
    end else if (pop) begin
      cnt_q <= cnt_q - 3'd1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_i) begin
      res_q <= burst_i.res;
      pts_q <= pts_i;
    end else if (pop) begin
      for (int i = 0; i < BurstMax - 1; i++) begin
        res_q[i] <= res_q[i+1];
      end
    end
  end

endmodule

// ===== test/annexb_nal_unit_splitter_tb.sv =====
// Testbench for annexb_nal_unit_splitter: drives Annex B frames and checks every NAL payload
// transfer against a scoreboard with its own start-code parser and timestamp split.
// Depends on anbs_pkg and the splitter RTL only.
`timescale 1ns / 100ps

module annexb_nal_unit_splitter_tb;
  import anbs_pkg::*;

  localparam int unsigned CycleLimit = 200000;
  localparam int unsigned HoldCycles = 300;
  localparam int unsigned RandomBytes = 180;
  localparam int unsigned DrainCycles = 20;
  localparam logic [63:0] UsecPerSec = 64'd1000000;

  typedef struct packed {
    res_t res;
    pts_t pts;
    logic burst_last;
  } payload_rec_t;

  class nal_scoreboard;
    logic [7:0]   held[4];
    int           held_cnt;
    bit           in_unit;
    bit           first_next;
    pts_t         cur_pts;
    payload_rec_t burst_q[$];
    payload_rec_t expected_q[$];
    int           checked;
    int           mismatches;

    function new();
      foreach (held[i]) held[i] = 8'h00;
      held_cnt   = 0;
      in_unit    = 1'b0;
      first_next = 1'b1;
      checked    = 0;
      mismatches = 0;
    endfunction

    function void put(logic [7:0] v, bit last);
      payload_rec_t rec;
      if (!in_unit || burst_q.size() >= BurstMax) return;
      rec.res.data   = v;
      rec.res.first  = first_next;
      rec.res.last   = last;
      rec.pts        = cur_pts;
      rec.burst_last = 1'b0;
      first_next     = 1'b0;
      burst_q.insert(burst_q.size(), rec);
    endfunction

    function void note_byte(logic [7:0] b, logic fe, logic [63:0] ts);
      int n;
      int tz;
      int z;
      int p;
      payload_rec_t rec;
      cur_pts.sec  = 45'(ts / UsecPerSec);
      cur_pts.usec = 20'(ts % UsecPerSec);
      n  = held_cnt;
      tz = 0;
      while (tz < n && held[n-1-tz] == 8'h00) tz++;
      if (b == 8'h00) begin
        if (n == LookDepth) begin
          put(held[0], 1'b0);
          for (int i = 0; i < 3; i++) held[i] = held[i+1];
          n = 3;
        end
        held[n] = 8'h00;
        n++;
      end else if (b == 8'h01 && tz >= 2) begin
        z = (tz < 3) ? tz : 3;
        p = n - z;
        for (int i = 0; i < p; i++) put(held[i], i + 1 == p);
        n          = 0;
        in_unit    = 1'b1;
        first_next = 1'b1;
      end else begin
        for (int i = 0; i < n; i++) put(held[i], 1'b0);
        held[0] = b;
        n       = 1;
      end
      if (fe) begin
        for (int i = 0; i < n; i++) put(held[i], i + 1 == n);
        n          = 0;
        in_unit    = 1'b0;
        first_next = 1'b1;
      end
      held_cnt = n;
      foreach (burst_q[i]) begin
        rec            = burst_q[i];
        rec.burst_last = (i == burst_q.size() - 1);
        expected_q.insert(expected_q.size(), rec);
      end
      burst_q.delete();
    endfunction

    task report(string what, logic [63:0] got, logic [63:0] want);
      mismatches++;
      $display("MISMATCH at transfer %0d, %s: got 0x%0h, expected 0x%0h",
               checked, what, got, want);
    endtask

    task check_transfer(logic [79:0] tdata, logic [1:0] tuser, logic tlast);
      payload_rec_t want;
      if (expected_q.size() == 0) begin
        report("transfer with nothing expected", 64'(tdata[7:0]), 64'd0);
        return;
      end
      want = expected_q[0];
      expected_q.delete(0);
      checked++;
      if (tdata[7:0] != want.res.data)
        report("payload_byte", 64'(tdata[7:0]), 64'(want.res.data));
      if (tuser[0] != want.res.first)
        report("unit_first", 64'(tuser[0]), 64'(want.res.first));
      if (tlast != want.res.last)
        report("unit_last", 64'(tlast), 64'(want.res.last));
      if (tdata[52:8] != want.pts.sec)
        report("pts_seconds", 64'(tdata[52:8]), 64'(want.pts.sec));
      if (tdata[72:53] != want.pts.usec)
        report("pts_micros", 64'(tdata[72:53]), 64'(want.pts.usec));
      if (tuser[1] != want.burst_last)
        report("burst_last", 64'(tuser[1]), 64'(want.burst_last));
    endtask
  endclass

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        s_tvalid = 1'b0;
  logic [71:0] s_tdata = '0;
  logic        s_tlast = 1'b0;
  logic        m_tready = 1'b0;
  logic        s_axis_tready_o;
  logic        m_axis_tvalid_o;
  logic [79:0] m_axis_tdata_o;
  logic [1:0]  m_axis_tuser_o;
  logic        m_axis_tlast_o;

  nal_scoreboard sb = new();
  int unsigned   cycle_cnt = 0;
  int            bytes_sent = 0;
  int            frames_sent = 0;
  int            random_bytes = 0;
  bit            send_quiet = 1'b0;
  bit            recv_quiet = 1'b0;
  bit            hold_out = 1'b0;
  bit            hold_done = 1'b0;
  bit            pause_done = 1'b0;

  annexb_nal_unit_splitter u_dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .s_axis_tvalid_i(s_tvalid),
    .s_axis_tready_o(s_axis_tready_o),
    .s_axis_tdata_i (s_tdata),
    .s_axis_tlast_i (s_tlast),
    .m_axis_tvalid_o(m_axis_tvalid_o),
    .m_axis_tready_i(m_tready),
    .m_axis_tdata_o (m_axis_tdata_o),
    .m_axis_tuser_o (m_axis_tuser_o),
    .m_axis_tlast_o (m_axis_tlast_o)
  );

  always #5 clk_i = ~clk_i;

  always @(posedge clk_i) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt >= CycleLimit) begin
      $display("Timeout after %0d cycles, %0d transfers still expected",
               cycle_cnt, sb.expected_q.size());
      $display("Some tests failed");
      $finish;
    end
  end

  function automatic logic [7:0] stream_byte();
    int r;
    r = $urandom_range(9, 0);
    if (r < 4) return 8'h00;
    if (r == 4) return 8'h01;
    return 8'($urandom);
  endfunction

  function automatic logic [63:0] pick_ts();
    case ($urandom_range(7, 0))
      0: return 64'd0;
      1: return '1;
      2: return UsecPerSec - 1;
      3: return UsecPerSec;
      default: return {$urandom, $urandom};
    endcase
  endfunction

  task automatic send_byte(input logic [7:0] b, input logic fe, input logic [63:0] ts);
    int gap;
    gap = send_quiet ? 0 : $urandom_range(14, 0);
    if (gap != 0) begin
      s_tvalid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    s_tvalid <= 1'b1;
    s_tdata  <= {ts, b};
    s_tlast  <= fe;
    do @(posedge clk_i); while (!s_axis_tready_o);
    sb.note_byte(b, fe, ts);
    bytes_sent++;
  endtask

  task automatic send_bytes(input logic [7:0] q[$], input logic [63:0] ts);
    foreach (q[i]) send_byte(q[i], i == q.size() - 1, ts);
    frames_sent++;
  endtask

  task automatic send_frame(input bit well_formed);
    logic [7:0] q[$];
    int zeros;
    if (well_formed) begin
      repeat ($urandom_range(2, 0)) q.insert(q.size(), stream_byte());
      repeat ($urandom_range(3, 1)) begin
        case ($urandom_range(3, 0))
          0: zeros = 3;
          1: zeros = $urandom_range(6, 4);
          default: zeros = 2;
        endcase
        repeat (zeros) q.insert(q.size(), 8'h00);
        q.insert(q.size(), 8'h01);
        repeat ($urandom_range(6, 0)) q.insert(q.size(), stream_byte());
      end
      repeat ($urandom_range(2, 0)) q.insert(q.size(), 8'h00);
    end else begin
      repeat ($urandom_range(8, 1)) q.insert(q.size(), stream_byte());
    end
    send_quiet = ($urandom_range(3, 0) == 0);
    send_bytes(q, pick_ts());
    random_bytes += q.size();
  endtask

  initial begin
    int stall;
    int moved;
    moved = 0;
    wait (rst_ni === 1'b1);
    @(posedge clk_i);
    forever begin
      if (hold_out) begin
        m_tready <= 1'b0;
        repeat (HoldCycles) @(posedge clk_i);
        hold_out = 1'b0;
      end
      stall = recv_quiet ? 0 : $urandom_range(14, 0);
      if (stall != 0) begin
        m_tready <= 1'b0;
        repeat (stall) @(posedge clk_i);
      end
      m_tready <= 1'b1;
      do @(posedge clk_i); while (!m_axis_tvalid_o);
      sb.check_transfer(m_axis_tdata_o, m_axis_tuser_o, m_axis_tlast_o);
      moved++;
      if (moved % 24 == 0) recv_quiet = ($urandom_range(2, 0) == 0);
    end
  end

  initial begin
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // junk, 3- and 4-byte start codes, long zero run, empty unit, trailing zeros at frame end
    send_bytes('{8'h55, 8'h00, 8'h00, 8'h01, 8'hFF, 8'h00, 8'h00, 8'h00, 8'h01, 8'h80,
                 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h01, 8'h00, 8'h00, 8'h01, 8'h7F,
                 8'h00}, 64'd0);
    // start code right at the frame end
    send_bytes('{8'h00, 8'h00, 8'h01}, '1);
    // no start code anywhere in the frame
    send_bytes('{8'h01, 8'hAA}, UsecPerSec - 1);

    while (random_bytes < RandomBytes) begin
      if (random_bytes >= 60 && !hold_done) begin
        hold_done = 1'b1;
        hold_out  = 1'b1;
      end
      if (random_bytes >= 120 && !pause_done) begin
        pause_done = 1'b1;
        s_tvalid <= 1'b0;
        @(posedge clk_i);
        while (sb.expected_q.size() != 0) @(posedge clk_i);
      end
      send_frame($urandom_range(4, 0) != 0);
    end

    s_tvalid <= 1'b0;
    s_tlast  <= 1'b0;
    while (sb.expected_q.size() != 0) @(posedge clk_i);
    repeat (DrainCycles) @(posedge clk_i);

    $display("Sent %0d bytes in %0d frames; %0d payload transfers checked, %0d mismatches",
             bytes_sent, frames_sent, sb.checked, sb.mismatches);
    $display("Included a %0d-cycle output hold-off and an input pause until drained",
             HoldCycles);
    if (sb.mismatches == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule
